FILE: rtl/tcd_pkg.sv
// Package for the touch calibration and tap detection block.
// Holds screen constants, configuration indexes, item classes and shared types.
// No dependencies.
`default_nettype none
package tcd_pkg;

	localparam int SCREEN_W    = 320;
	localparam int SCREEN_H    = 240;
	localparam int EDGE_MARGIN = 24;

	localparam int RAW_W   = 12;
	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int AGE_W   = 32;
	localparam int COORD_W = 10;

	localparam int SPAN_X   = SCREEN_W - 2 * EDGE_MARGIN;
	localparam int SPAN_Y   = SCREEN_H - 2 * EDGE_MARGIN;
	localparam int SPAN_MAX = (SPAN_X > SPAN_Y) ? SPAN_X : SPAN_Y;
	localparam int NUM_W    = RAW_W + $clog2(SPAN_MAX + 1);
	localparam int V_W      = NUM_W + 3;
	localparam int CNT_W    = $clog2(NUM_W);

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RAW_W;

	localparam logic [RAW_W-1:0] CAL_LOW_RST  = RAW_W'(200);
	localparam logic [RAW_W-1:0] CAL_HIGH_RST = RAW_W'(3900);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_LOW  = 3'd0,
		CFG_X_HIGH = 3'd1,
		CFG_Y_LOW  = 3'd2,
		CFG_Y_HIGH = 3'd3,
		CFG_FLIP   = 3'd4
	} tcd_cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_PRESS,
		KIND_RELEASE
	} tcd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_FIN
	} tcd_state_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_low;
		logic [RAW_W-1:0] x_high;
		logic [RAW_W-1:0] y_low;
		logic [RAW_W-1:0] y_high;
		logic             flip;
	} tcd_cfg_t;

	typedef struct packed {
		tcd_kind_t        kind;
		logic [NUM_W-1:0] num_x;
		logic [RAW_W-1:0] den_x;
		logic             neg_x;
		logic             zero_x;
		logic [NUM_W-1:0] num_y;
		logic [RAW_W-1:0] den_y;
		logic             neg_y;
		logic             zero_y;
	} tcd_work_t;

	typedef struct packed {
		logic             tap;
		logic [X_W-1:0]   tap_x;
		logic [Y_W-1:0]   tap_y;
		logic             now_pressed;
		logic [X_W-1:0]   screen_x;
		logic [Y_W-1:0]   screen_y;
		logic [AGE_W-1:0] ms_since_tap;
	} tcd_result_t;

endpackage
`default_nettype wire

FILE: rtl/tcd_if.sv
// Channel interfaces for the touch calibration and tap detection block.
// Depends on tcd_pkg for field widths.
`default_nettype none
interface tcd_req_if;
	import tcd_pkg::*;
	logic             valid;
	logic             ready;
	logic             mode;
	logic             pressed;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;

	modport source (output valid, mode, pressed, raw_x, raw_y, input ready);
	modport sink (input valid, mode, pressed, raw_x, raw_y, output ready);
endinterface

interface tcd_rsp_if;
	import tcd_pkg::*;
	logic             valid;
	logic             ready;
	logic             tap;
	logic [X_W-1:0]   tap_x;
	logic [Y_W-1:0]   tap_y;
	logic             now_pressed;
	logic [X_W-1:0]   screen_x;
	logic [Y_W-1:0]   screen_y;
	logic [AGE_W-1:0] ms_since_tap;

	modport source (output valid, tap, tap_x, tap_y, now_pressed, screen_x, screen_y,
		ms_since_tap, input ready);
	modport sink (input valid, tap, tap_x, tap_y, now_pressed, screen_x, screen_y,
		ms_since_tap, output ready);
endinterface
`default_nettype wire

FILE: rtl/tcd_front.sv
// Front end: accepts items, classifies them and forms the scaled numerators and spans.
// Depends on tcd_pkg and tcd_req_if.
`default_nettype none
module tcd_front (
	tcd_req_if.sink          req,
	input  tcd_pkg::tcd_cfg_t  cfg,
	input  logic             q_full,
	output logic             q_push,
	output tcd_pkg::tcd_work_t q_entry
);
	import tcd_pkg::*;

	logic [RAW_W:0]   diff_x, diff_y;
	logic [RAW_W-1:0] mag_x, mag_y;
	logic             below_x, below_y;
	logic             span_neg_x, span_neg_y;

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	always_comb begin
		diff_x  = {1'b0, req.raw_x} - {1'b0, cfg.x_low};
		diff_y  = {1'b0, req.raw_y} - {1'b0, cfg.y_low};
		below_x = diff_x[RAW_W];
		below_y = diff_y[RAW_W];
		mag_x   = below_x ? (cfg.x_low - req.raw_x) : diff_x[RAW_W-1:0];
		mag_y   = below_y ? (cfg.y_low - req.raw_y) : diff_y[RAW_W-1:0];
		span_neg_x = cfg.x_high < cfg.x_low;
		span_neg_y = cfg.y_high < cfg.y_low;

		if (req.mode) begin
			q_entry.kind = KIND_TICK;
		end else if (req.pressed) begin
			q_entry.kind = KIND_PRESS;
		end else begin
			q_entry.kind = KIND_RELEASE;
		end
		q_entry.num_x  = NUM_W'(mag_x * SPAN_X);
		q_entry.num_y  = NUM_W'(mag_y * SPAN_Y);
		q_entry.den_x  = span_neg_x ? (cfg.x_low - cfg.x_high) : (cfg.x_high - cfg.x_low);
		q_entry.den_y  = span_neg_y ? (cfg.y_low - cfg.y_high) : (cfg.y_high - cfg.y_low);
		q_entry.neg_x  = below_x ^ span_neg_x;
		q_entry.neg_y  = below_y ^ span_neg_y;
		q_entry.zero_x = cfg.x_high == cfg.x_low;
		q_entry.zero_y = cfg.y_high == cfg.y_low;
	end
endmodule
`default_nettype wire

FILE: rtl/tcd_queue.sv
// Short queue between the front end and the back end.
// Depends on tcd_pkg for the entry type and depth.
`default_nettype none
module tcd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tcd_pkg::tcd_work_t push_entry,
	output logic               full,
	input  logic               pop,
	output tcd_pkg::tcd_work_t head,
	output logic               empty
);
	import tcd_pkg::*;

	tcd_work_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full  = count_q == (Q_AW+1)'(Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tcd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tcd_pkg for operand widths.
`default_nettype none
module tcd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tcd_pkg::NUM_W-1:0] num,
	input  logic [tcd_pkg::RAW_W-1:0] den,
	output logic                      done,
	output logic [tcd_pkg::NUM_W-1:0] quo
);
	import tcd_pkg::*;

	logic [RAW_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [RAW_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? RAW_W'(trial - {1'b0, den_q}) : trial[RAW_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tcd_back.sv
// Back end: runs the divisions, finishes the mapping and keeps tap state and age.
// Depends on tcd_pkg and tcd_div.
`default_nettype none
module tcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcd_pkg::tcd_cfg_t    cfg,
	input  logic                q_empty,
	input  tcd_pkg::tcd_work_t   q_head,
	output logic                q_pop,
	output logic                res_valid,
	output tcd_pkg::tcd_result_t res,
	input  logic                res_ready
);
	import tcd_pkg::*;

	tcd_state_t       state_q, state_d;
	tcd_work_t        work_q;
	logic [COORD_W-1:0] sx_q, sy_q;
	logic             was_pressed_q;
	logic [X_W-1:0]   held_x_q;
	logic [Y_W-1:0]   held_y_q;
	logic [AGE_W-1:0] tap_age_q;
	logic             res_valid_q;
	tcd_result_t      res_q, res_d;
	logic             slot_free;
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [RAW_W-1:0] div_den;
	logic             is_tap;

	function automatic logic [COORD_W-1:0] map_finish(input logic [NUM_W-1:0] q,
		input logic neg, input logic zero, input logic flip, input int size);
		logic signed [V_W-1:0] v;
		logic signed [V_W-1:0] top_v;
		top_v = V_W'(size - 1);
		if (zero) begin
			v = V_W'(EDGE_MARGIN);
		end else begin
			v = $signed({3'b000, q});
			if (neg) begin
				v = -v;
			end
			v = v + V_W'(EDGE_MARGIN);
		end
		if (flip) begin
			v = top_v - v;
		end
		if (v < 0) begin
			v = '0;
		end else if (v > top_v) begin
			v = top_v;
		end
		return COORD_W'(v);
	endfunction

	tcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign slot_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign is_tap    = (work_q.kind == KIND_RELEASE) && was_pressed_q;

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = q_head.num_x;
		div_den   = q_head.den_x;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_head.kind == KIND_PRESS) begin
						div_start = 1'b1;
						state_d   = ST_DIV_X;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV_X: begin
				div_num = work_q.num_y;
				div_den = work_q.den_y;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res_d = '0;
		case (work_q.kind)
			KIND_TICK: begin
				res_d.ms_since_tap = tap_age_q + 1'b1;
			end
			KIND_PRESS: begin
				res_d.now_pressed  = 1'b1;
				res_d.screen_x     = sx_q[X_W-1:0];
				res_d.screen_y     = sy_q[Y_W-1:0];
				res_d.ms_since_tap = tap_age_q;
			end
			default: begin
				res_d.tap          = is_tap;
				res_d.tap_x        = is_tap ? held_x_q : '0;
				res_d.tap_y        = is_tap ? held_y_q : '0;
				res_d.ms_since_tap = is_tap ? '0 : tap_age_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_valid_q   <= 1'b0;
			was_pressed_q <= 1'b0;
			held_x_q      <= '0;
			held_y_q      <= '0;
			tap_age_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && slot_free) begin
				res_valid_q <= 1'b1;
				tap_age_q   <= res_d.ms_since_tap;
				if (work_q.kind == KIND_PRESS) begin
					was_pressed_q <= 1'b1;
					held_x_q      <= sx_q[X_W-1:0];
					held_y_q      <= sy_q[Y_W-1:0];
				end else if (work_q.kind == KIND_RELEASE) begin
					was_pressed_q <= 1'b0;
				end
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_head;
		end
		if (state_q == ST_DIV_X && div_done) begin
			sx_q <= map_finish(div_quo, work_q.neg_x, work_q.zero_x, cfg.flip, SCREEN_W);
		end
		if (state_q == ST_DIV_Y && div_done) begin
			sy_q <= map_finish(div_quo, work_q.neg_y, work_q.zero_y, cfg.flip, SCREEN_H);
		end
		if (state_q == ST_FIN && slot_free) begin
			res_q <= res_d;
		end
	end

	a_tap_clears_age: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.tap) |-> (res_q.ms_since_tap == '0))
		else $error("tap result with nonzero age");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !slot_free) |=> (state_q == ST_FIN))
		else $error("result slot overwritten");

	a_x_then_y: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_X && div_done) |=> (state_q == ST_DIV_Y))
		else $error("y division did not follow x");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != ST_IDLE))
		else $error("popped item was not taken up");
endmodule
`default_nettype wire

FILE: rtl/touch_calibrate_tap_detect_unit.sv
// Top level of the touch calibration and tap detection block.
// Depends on tcd_pkg, tcd_if, tcd_front, tcd_queue and tcd_back.
//
// Items arrive on req: a tick (mode 1) or a touch sample with pressed, raw_x and raw_y.
// Each item gives exactly one result on rsp, in order, with valid/ready handshakes.
// Calibration registers are written through cfg_we, cfg_index and cfg_data. The user
// must write them only while idle; the block itself does not enforce it. The front end
// classifies an item and forms its scaled numerators in the cycle it is accepted, then
// stores it in a two-entry queue. The back end takes one item at a time. A tick or
// release result needs no division. A pressed sample runs two 21-step divisions, x then
// y, on one shared restoring divider before its result is valid.
// The result register frees the back end as soon as rsp takes it.
// When rsp stalls, the result holds and the back end waits; the queue still takes up to
// two more items before req.ready drops. Reset empties the queue, clears the pressed
// state, held position and age, and loads the default calibration.
`default_nettype none
module touch_calibrate_tap_detect_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	tcd_req_if.sink                        req,
	tcd_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [tcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcd_pkg::*;

	tcd_cfg_t    cfg_q;
	tcd_work_t   push_entry, head;
	tcd_result_t res;
	logic        q_full, q_empty, q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low  <= CAL_LOW_RST;
			cfg_q.x_high <= CAL_HIGH_RST;
			cfg_q.y_low  <= CAL_LOW_RST;
			cfg_q.y_high <= CAL_HIGH_RST;
			cfg_q.flip   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_LOW:  cfg_q.x_low  <= cfg_data;
				CFG_X_HIGH: cfg_q.x_high <= cfg_data;
				CFG_Y_LOW:  cfg_q.y_low  <= cfg_data;
				CFG_Y_HIGH: cfg_q.y_high <= cfg_data;
				CFG_FLIP:   cfg_q.flip   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tcd_front u_front (
		.req     (req),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (push_entry)
	);

	tcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head),
		.empty      (q_empty)
	);

	tcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (head),
		.q_pop     (q_pop),
		.res_valid (rsp.valid),
		.res       (res),
		.res_ready (rsp.ready)
	);

	assign rsp.tap          = res.tap;
	assign rsp.tap_x        = res.tap_x;
	assign rsp.tap_y        = res.tap_y;
	assign rsp.now_pressed  = res.now_pressed;
	assign rsp.screen_x     = res.screen_x;
	assign rsp.screen_y     = res.screen_y;
	assign rsp.ms_since_tap = res.ms_since_tap;
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for touch_calibrate_tap_detect_unit: directed and random touch samples and ticks.
// A predictor computes each result as the item is accepted, and a checker compares it.
// Depends on tcd_pkg, tcd_if and the RTL of the block.
module tb_top;
	import tcd_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	tcd_cfg_idx_t          cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tcd_req_if req_ch ();
	tcd_rsp_if rsp_ch ();

	touch_calibrate_tap_detect_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcd_cfg_t         cal;
	logic             was_down;
	logic [X_W-1:0]   last_x;
	logic [Y_W-1:0]   last_y;
	logic [AGE_W-1:0] age;

	tcd_result_t pending_results[$];
	tcd_result_t want;
	int          err_count    = 0;
	int          items_sent   = 0;
	int          results_seen = 0;
	int          hold_off     = 0;
	int          cycles       = 0;
	bit          idling       = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int map_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
		logic [RAW_W-1:0] hi, int size, bit flip);
		longint r, l, h, v;
		r = raw;
		l = lo;
		h = hi;
		if (h == l) begin
			v = EDGE_MARGIN;
		end else begin
			v = (r - l) * (size - 2 * EDGE_MARGIN) / (h - l) + EDGE_MARGIN;
		end
		if (flip) begin
			v = size - 1 - v;
		end
		if (v < 0) begin
			v = 0;
		end
		if (v > size - 1) begin
			v = size - 1;
		end
		return int'(v);
	endfunction

	function automatic tcd_result_t predict_touch(logic m, logic p, logic [RAW_W-1:0] rx,
		logic [RAW_W-1:0] ry);
		tcd_result_t r;
		r = '0;
		if (m) begin
			age = age + 1'b1;
		end else begin
			if (p) begin
				r.screen_x    = X_W'(map_axis(rx, cal.x_low, cal.x_high, SCREEN_W, cal.flip));
				r.screen_y    = Y_W'(map_axis(ry, cal.y_low, cal.y_high, SCREEN_H, cal.flip));
				r.now_pressed = 1'b1;
			end
			if (!p && was_down) begin
				r.tap   = 1'b1;
				r.tap_x = last_x;
				r.tap_y = last_y;
				age     = '0;
			end
			was_down = p;
			if (p) begin
				last_x = r.screen_x;
				last_y = r.screen_y;
			end
		end
		r.ms_since_tap = age;
		return r;
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
		if ($urandom_range(0, 3) == 0) begin
			return RAW_W'($urandom);
		end
		return RAW_W'($urandom_range(lo, hi));
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
		$display("ERROR result %0d: %s got %0d wanted %0d", results_seen, what, got, exp_val);
		err_count++;
	endtask

	// The receiver: a long hold-off when a test sets one, then random stall bursts while idling is on.
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 11);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending, age", rsp_ch.ms_since_tap, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.tap !== want.tap)
					report_mismatch("tap", rsp_ch.tap, want.tap);
				if (rsp_ch.tap_x !== want.tap_x)
					report_mismatch("tap_x", rsp_ch.tap_x, want.tap_x);
				if (rsp_ch.tap_y !== want.tap_y)
					report_mismatch("tap_y", rsp_ch.tap_y, want.tap_y);
				if (rsp_ch.now_pressed !== want.now_pressed)
					report_mismatch("now_pressed", rsp_ch.now_pressed, want.now_pressed);
				if (rsp_ch.screen_x !== want.screen_x)
					report_mismatch("screen_x", rsp_ch.screen_x, want.screen_x);
				if (rsp_ch.screen_y !== want.screen_y)
					report_mismatch("screen_y", rsp_ch.screen_y, want.screen_y);
				if (rsp_ch.ms_since_tap !== want.ms_since_tap)
					report_mismatch("ms_since_tap", rsp_ch.ms_since_tap, want.ms_since_tap);
			end
			results_seen++;
		end
	end

	task automatic send_item(logic m, logic p, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
		int gap;
		gap = 0;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.mode    <= m;
		req_ch.pressed <= p;
		req_ch.raw_x   <= rx;
		req_ch.raw_y   <= ry;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		pending_results.push_back(predict_touch(m, p, rx, ry));
		items_sent++;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(tcd_cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_X_LOW: begin
				cal.x_low = d;
			end
			CFG_X_HIGH: begin
				cal.x_high = d;
			end
			CFG_Y_LOW: begin
				cal.y_low = d;
			end
			CFG_Y_HIGH: begin
				cal.y_high = d;
			end
			CFG_FLIP: begin
				cal.flip = d[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_cal(logic [RAW_W-1:0] xl, logic [RAW_W-1:0] xh, logic [RAW_W-1:0] yl,
		logic [RAW_W-1:0] yh, logic flip);
		write_reg(CFG_X_LOW, xl);
		write_reg(CFG_X_HIGH, xh);
		write_reg(CFG_Y_LOW, yl);
		write_reg(CFG_Y_HIGH, yh);
		write_reg(CFG_FLIP, CFG_DATA_W'(flip));
	endtask

	task automatic random_cal();
		logic [RAW_W-1:0] lo[2];
		logic [RAW_W-1:0] hi[2];
		int k;
		for (int a = 0; a < 2; a++) begin
			k = $urandom_range(0, 9);
			if (k < 5) begin
				lo[a] = RAW_W'($urandom_range(0, 600));
				hi[a] = RAW_W'($urandom_range(3400, 4095));
			end else if (k < 6) begin
				lo[a] = RAW_W'($urandom);
				hi[a] = lo[a];
			end else if (k < 8) begin
				lo[a] = RAW_W'($urandom_range(3000, 4095));
				hi[a] = RAW_W'($urandom_range(0, 1000));
			end else if (k < 9) begin
				lo[a] = RAW_W'($urandom_range(0, 4000));
				hi[a] = lo[a] + RAW_W'($urandom_range(1, 40));
			end else begin
				lo[a] = RAW_W'($urandom);
				hi[a] = RAW_W'($urandom);
			end
		end
		set_cal(lo[0], hi[0], lo[1], hi[1], 1'($urandom_range(0, 1)));
	endtask

	// Mostly press strokes ending in a release, with ticks mixed in, plus some noise.
	task automatic run_gestures(int n);
		int stop, k, len;
		stop = items_sent + n;
		while (items_sent < stop) begin
			k = $urandom_range(0, 9);
			if (k < 7) begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					if ($urandom_range(0, 3) == 0) begin
						send_item(1'b1, 1'($urandom), RAW_W'($urandom), RAW_W'($urandom));
					end
					send_item(1'b0, 1'b1, pick_raw(cal.x_low, cal.x_high),
						pick_raw(cal.y_low, cal.y_high));
				end
				send_item(1'b0, 1'b0, RAW_W'($urandom), RAW_W'($urandom));
			end else if (k < 9) begin
				repeat ($urandom_range(1, 5)) begin
					send_item(1'b1, 1'($urandom), RAW_W'($urandom), RAW_W'($urandom));
				end
			end else begin
				send_item(1'($urandom), 1'($urandom), RAW_W'($urandom), RAW_W'($urandom));
			end
		end
	endtask

	task automatic test_default_map();
		send_item(1'b1, 1'b0, 12'd0, 12'd0);
		send_item(1'b0, 1'b1, 12'd0, 12'd0);
		send_item(1'b0, 1'b1, 12'hFFF, 12'hFFF);
		send_item(1'b0, 1'b1, 12'd200, 12'd3900);
		send_item(1'b0, 1'b1, 12'd3900, 12'd200);
		send_item(1'b0, 1'b0, 12'hABC, 12'h123);
		send_item(1'b0, 1'b0, 12'hFFF, 12'hFFF);
		send_item(1'b1, 1'b1, 12'hFFF, 12'hFFF);
		settle();
	endtask

	task automatic test_zero_span();
		set_cal(12'd2048, 12'd2048, 12'd0, 12'd0, 1'b1);
		send_item(1'b0, 1'b1, 12'd2048, 12'd0);
		send_item(1'b0, 1'b1, 12'hFFF, 12'hFFF);
		send_item(1'b1, 1'b0, 12'd0, 12'd0);
		send_item(1'b0, 1'b0, 12'd0, 12'd0);
		settle();
	endtask

	task automatic test_reversed_span();
		set_cal(12'hFFF, 12'd0, 12'd3000, 12'd100, 1'b0);
		send_item(1'b0, 1'b1, 12'd0, 12'd0);
		send_item(1'b0, 1'b1, 12'hFFF, 12'hFFF);
		send_item(1'b0, 1'b1, 12'd1234, 12'd3500);
		send_item(1'b0, 1'b0, 12'd0, 12'd0);
		settle();
		write_reg(CFG_FLIP, 12'd1);
		send_item(1'b0, 1'b1, 12'd0, 12'hFFF);
		send_item(1'b0, 1'b0, 12'd0, 12'd0);
		settle();
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		set_cal(12'd200, 12'd3900, 12'd200, 12'd3900, 1'b0);
		idling   = 1'b0;
		hold_off = 300;
		repeat (3) begin
			send_item(1'b0, 1'b1, RAW_W'($urandom), RAW_W'($urandom));
			send_item(1'b1, 1'b0, RAW_W'($urandom), RAW_W'($urandom));
			send_item(1'b0, 1'b0, RAW_W'($urandom), RAW_W'($urandom));
		end
		settle();
		idling = 1'b1;
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 5; phase++) begin
			random_cal();
			idling = (phase != 4);
			run_gestures(160);
			settle();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_X_LOW;
		cfg_data       = '0;
		req_ch.valid   = 1'b0;
		req_ch.mode    = 1'b0;
		req_ch.pressed = 1'b0;
		req_ch.raw_x   = '0;
		req_ch.raw_y   = '0;
		cal.x_low      = CAL_LOW_RST;
		cal.x_high     = CAL_HIGH_RST;
		cal.y_low      = CAL_LOW_RST;
		cal.y_high     = CAL_HIGH_RST;
		cal.flip       = 1'b0;
		was_down       = 1'b0;
		last_x         = '0;
		last_y         = '0;
		age            = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_map();
		test_zero_span();
		test_reversed_span();
		test_backpressure();
		test_random();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/tcd_pkg.sv
rtl/tcd_if.sv
rtl/tcd_front.sv
rtl/tcd_queue.sv
rtl/tcd_div.sv
rtl/tcd_back.sv
rtl/touch_calibrate_tap_detect_unit.sv
sim/tb_top.sv
